// ===== hdl/nws_pkg.sv =====
`default_nettype none
package nws_pkg;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CONV_LAT, ST_CONV_LON, ST_CONV_END,
      ST_SC_WRAP, ST_SC_FOLD, ST_SC_RUN, ST_SC_FIN,
      ST_RD_ISSUE, ST_RD_WAIT,
      ST_P_RSWS, ST_P_RCWC, ST_P_DC, ST_P_SUM, ST_P_SQ, ST_P_SQ2, ST_SQRT,
      ST_VC_LOAD, ST_VC_RUN, ST_VC_FIN, ST_D_CMP,
      ST_B_T1, ST_B_A, ST_B_B, ST_B_C, ST_B_D, ST_B_WRAP,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {PH_LOAD, PH_REF, PH_SCAN, PH_BEAR} phase_type;

   typedef enum logic [1:0] {SH_29, SH_30, SH_38} shift_type;

   typedef struct packed {
      logic [31:0] lon;
      logic [31:0] sin;
      logic [31:0] cos;
   } wp_type;

   localparam logic REG_WAYPOINT_COUNT = 1'b0;

   localparam logic [4:0] CORDIC_LAST = 5'd29;

   localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
   localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [35:0] CORDIC_SCALE = 36'sd652032874;
   localparam logic signed [35:0] ONE_Q30_X   = 36'sd1073741824;
   localparam logic signed [33:0] ONE_Q30_S   = 34'sd1073741824;

   localparam logic signed [31:0] DEG2RAD_K = 32'sd1199381129;
   localparam logic signed [31:0] RAD2DEG_K = 32'sd961263669;
   localparam logic signed [31:0] KM_K      = 32'sd1630976;

   localparam logic signed [29:0] LAT_LIMIT = 30'sd377487360;
   localparam logic signed [30:0] LON_LIMIT = 31'sd754974720;
   localparam logic signed [66:0] DIST_MAX  = 67'sd8388607;
   localparam logic signed [27:0] FULL_TURN = 28'sd23592960;

   function automatic logic [29:0] atan_lookup(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0:  v = 30'h3243F6A8;
         5'd1:  v = 30'h1DAC6705;
         5'd2:  v = 30'h0FADBAFC;
         5'd3:  v = 30'h07F56EA6;
         5'd4:  v = 30'h03FEAB76;
         5'd5:  v = 30'h01FFD55B;
         5'd6:  v = 30'h00FFFAAA;
         5'd7:  v = 30'h007FFF55;
         5'd8:  v = 30'h003FFFEA;
         5'd9:  v = 30'h001FFFFD;
         5'd10: v = 30'h000FFFFF;
         5'd11: v = 30'h0007FFFF;
         5'd12: v = 30'h0003FFFF;
         5'd13: v = 30'h0001FFFF;
         5'd14: v = 30'h0000FFFF;
         5'd15: v = 30'h00007FFF;
         5'd16: v = 30'h00003FFF;
         5'd17: v = 30'h00001FFF;
         5'd18: v = 30'h00000FFF;
         5'd19: v = 30'h000007FF;
         5'd20: v = 30'h000003FF;
         5'd21: v = 30'h000001FF;
         5'd22: v = 30'h000000FF;
         5'd23: v = 30'h0000007F;
         5'd24: v = 30'h0000003F;
         5'd25: v = 30'h0000001F;
         5'd26: v = 30'h0000000F;
         5'd27: v = 30'h00000007;
         5'd28: v = 30'h00000003;
         5'd29: v = 30'h00000001;
         default: v = 30'h0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/nearest_waypoint_search_core.sv =====
// nearest waypoint search on a sphere, spherical law of cosines
// req channel (valid/stall): func 0 loads waypoint entry_index from lat_deg/lon_deg,
// func 1 queries the nearest loaded waypoint to lat_deg/lon_deg. req_stall is high
// while an item is in work; one item is in the block at a time.
// rsp channel (valid/stall): one transaction per query, none per load. It gives the
// first slot with the least distance, the distance in km*256, the bearing in
// degrees*65536 and table_empty when waypoint_count is zero.
// waypoint_count is written over the APB port at byte address 0.
// all trig runs on one shared CORDIC unit stepping one iteration per cycle, with one
// shared multiplier and a bit-pair square root unit; the per-waypoint cost is two
// CORDIC passes and a 31-step square root.
// the result waits in an output register; the next item is taken while it waits, and
// a finished query holds until that register is free.
// synchronous reset returns to idle, drops rsp_valid and clears waypoint_count;
// the waypoint store is not cleared and must be loaded before it is searched.
`default_nettype none
module nearest_waypoint_search_core
   import nws_pkg::*;
#(
   parameter int MAX_WAYPOINTS = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [0:0]         req_func,
   input  wire logic [7:0]         req_entry_index,
   input  wire logic signed [29:0] req_lat_deg,
   input  wire logic signed [30:0] req_lon_deg,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_nearest_index,
   output logic [22:0]             rsp_distance_km,
   output logic [24:0]             rsp_bearing_deg,
   output logic [0:0]              rsp_table_empty,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
   localparam int IW = (AW + 1 > 9) ? AW + 1 : 9;

   state_type state_ff, state_in;
   phase_type phase_ff;
   shift_type sh_ff, mul_sh;

   logic                    func_ff;
   logic [7:0]              eidx_ff;
   logic signed [29:0]      lat_ff;
   logic signed [30:0]      lon_ff;
   logic signed [31:0]      lat_r_ff, lon_r_ff;
   logic signed [66:0]      prod_ff;
   logic signed [34:0]      mul_a;
   logic signed [31:0]      mul_b;
   logic signed [35:0]      cx_ff, cy_ff;
   logic signed [34:0]      cz_ff;
   logic [4:0]              step_ff;
   logic                    neg_ff, vzero_ff;
   logic signed [31:0]      rs_ff, rc_ff, ds_ff, dc_ff, cang_ff;
   logic signed [32:0]      t1_ff;
   logic signed [33:0]      t2_ff;
   logic [61:0]             sqv_ff, sqr_ff;
   logic [4:0]              sqk_ff;
   logic [IW-1:0]           idx_ff, bi_ff, n_w, idx_nx;
   logic [22:0]             best_ff;
   logic [24:0]             bear_ff;
   logic                    empty_ff;
   logic [8:0]              count_ff;
   logic                    rsp_valid_ff;
   logic [7:0]              rsp_idx_ff;
   logic [22:0]             rsp_dist_ff;
   logic [24:0]             rsp_bear_ff;
   logic                    rsp_empty_ff;

   wp_type                  wp_mem [MAX_WAYPOINTS];
   wp_type                  rd_ff, wr_data;
   logic                    mem_we, rd_en, slot_ok;
   logic [AW-1:0]           wr_addr, rd_addr;

   logic signed [66:0]      rnd_sum, rnd_full;
   logic signed [35:0]      xs, ys, cx_nx, cy_nx, sc_x, sc_y;
   logic signed [34:0]      cz_nx, atan_v, z_fin;
   logic                    rot_dir;
   logic signed [31:0]      sc_cos, sc_sin;
   logic signed [33:0]      cang_sum;
   logic [61:0]             sq_bit, sq_trial;
   logic signed [35:0]      vx_src, vy_src;
   logic [22:0]             d_val;
   logic signed [27:0]      b_raw, b_w1, b_w2;
   logic signed [32:0]      dl_diff;
   logic                    rsp_free, cfg_write;

   // ---------------- configuration port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_WAYPOINT_COUNT) ? {23'd0, count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 9'd0;
      end else if (cfg_write && paddr[2] == REG_WAYPOINT_COUNT) begin
         count_ff <= pwdata[8:0];
      end
   end

   // ---------------- handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_idx_ff;
   assign rsp_distance_km   = rsp_dist_ff;
   assign rsp_bearing_deg   = rsp_bear_ff;
   assign rsp_table_empty   = rsp_empty_ff;

   assign n_w = (IW'(count_ff) > IW'(MAX_WAYPOINTS)) ? IW'(MAX_WAYPOINTS) : IW'(count_ff);
   assign slot_ok = (32'(eidx_ff) < 32'(MAX_WAYPOINTS));
   assign idx_nx  = idx_ff + IW'(1);

   // ---------------- shared multiplier with round half away from zero
   always_comb begin
      case (sh_ff)
         SH_29:   rnd_sum = prod_ff + 67'sd268435456 - 67'(prod_ff[66]);
         SH_38:   rnd_sum = prod_ff + 67'sd137438953472 - 67'(prod_ff[66]);
         default: rnd_sum = prod_ff + 67'sd536870912 - 67'(prod_ff[66]);
      endcase
      case (sh_ff)
         SH_29:   rnd_full = rnd_sum >>> 29;
         SH_38:   rnd_full = rnd_sum >>> 38;
         default: rnd_full = rnd_sum >>> 30;
      endcase
   end

   // ---------------- shared cordic step
   assign rot_dir = (state_ff == ST_SC_RUN) ? !cz_ff[34] : cy_ff[35];
   assign xs      = cx_ff >>> step_ff;
   assign ys      = cy_ff >>> step_ff;
   assign atan_v  = $signed({5'd0, atan_lookup(step_ff)});
   assign cx_nx   = rot_dir ? cx_ff - ys : cx_ff + ys;
   assign cy_nx   = rot_dir ? cy_ff + xs : cy_ff - xs;
   assign cz_nx   = rot_dir ? cz_ff - atan_v : cz_ff + atan_v;

   assign sc_x = neg_ff ? -cx_ff : cx_ff;
   assign sc_y = neg_ff ? -cy_ff : cy_ff;
   assign sc_cos = (sc_x > ONE_Q30_X) ? 32'sd1073741824 :
                   (sc_x < -ONE_Q30_X) ? -32'sd1073741824 : sc_x[31:0];
   assign sc_sin = (sc_y > ONE_Q30_X) ? 32'sd1073741824 :
                   (sc_y < -ONE_Q30_X) ? -32'sd1073741824 : sc_y[31:0];
   assign z_fin  = vzero_ff ? 35'sd0 : cz_ff;

   // ---------------- misc datapath terms
   assign cang_sum = {t1_ff[32], t1_ff} + {rnd_full[32], $signed(rnd_full[32:0])};
   assign sq_bit   = 62'd1 << {sqk_ff, 1'b0};
   assign sq_trial = sqr_ff + sq_bit;
   assign vx_src   = (phase_ff == PH_BEAR) ? 36'(t2_ff) : 36'(cang_ff);
   assign vy_src   = (phase_ff == PH_BEAR) ? 36'(t1_ff) : $signed({5'd0, sqr_ff[30:0]});
   assign d_val    = (rnd_full < 67'sd0) ? 23'd0 :
                     (rnd_full > DIST_MAX) ? 23'h7FFFFF : rnd_full[22:0];
   assign b_raw    = $signed(rnd_full[27:0]);
   assign b_w1     = (b_raw < 28'sd0) ? b_raw + FULL_TURN : b_raw;
   assign b_w2     = (b_w1 >= FULL_TURN) ? b_w1 - FULL_TURN : b_w1;
   assign dl_diff  = {rd_ff.lon[31], rd_ff.lon} - {lon_r_ff[31], lon_r_ff};

   // ---------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_CONV_LAT;
         ST_CONV_LAT: state_in = ST_CONV_LON;
         ST_CONV_LON: state_in = ST_CONV_END;
         ST_CONV_END: begin
            if (!func_ff) state_in = slot_ok ? ST_SC_WRAP : ST_IDLE;
            else          state_in = (n_w == '0) ? ST_RESULT : ST_SC_WRAP;
         end
         ST_SC_WRAP:  state_in = ST_SC_FOLD;
         ST_SC_FOLD:  state_in = ST_SC_RUN;
         ST_SC_RUN:   if (step_ff == CORDIC_LAST) state_in = ST_SC_FIN;
         ST_SC_FIN: begin
            case (phase_ff)
               PH_LOAD: state_in = ST_IDLE;
               PH_REF:  state_in = ST_RD_ISSUE;
               PH_SCAN: state_in = ST_P_RSWS;
               default: state_in = ST_B_T1;
            endcase
         end
         ST_RD_ISSUE: state_in = ST_RD_WAIT;
         ST_RD_WAIT:  state_in = ST_SC_WRAP;
         ST_P_RSWS:   state_in = ST_P_RCWC;
         ST_P_RCWC:   state_in = ST_P_DC;
         ST_P_DC:     state_in = ST_P_SUM;
         ST_P_SUM:    state_in = ST_P_SQ;
         ST_P_SQ:     state_in = ST_P_SQ2;
         ST_P_SQ2:    state_in = ST_SQRT;
         ST_SQRT:     if (sqk_ff == 5'd0) state_in = ST_VC_LOAD;
         ST_VC_LOAD:  state_in = ST_VC_RUN;
         ST_VC_RUN:   if (step_ff == CORDIC_LAST) state_in = ST_VC_FIN;
         ST_VC_FIN:   state_in = (phase_ff == PH_BEAR) ? ST_B_WRAP : ST_D_CMP;
         ST_D_CMP:    state_in = ST_RD_ISSUE;
         ST_B_T1:     state_in = ST_B_A;
         ST_B_A:      state_in = ST_B_B;
         ST_B_B:      state_in = ST_B_C;
         ST_B_C:      state_in = ST_B_D;
         ST_B_D:      state_in = ST_VC_LOAD;
         ST_B_WRAP:   state_in = ST_RESULT;
         ST_RESULT:   if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // ---------------- control outputs
   always_comb begin
      mul_a  = 35'sd0;
      mul_b  = 32'sd0;
      mul_sh = SH_30;
      mem_we = 1'b0;
      rd_en  = 1'b0;
      case (state_ff)
         ST_CONV_LAT: begin
            mul_a = 35'(lat_ff); mul_b = DEG2RAD_K; mul_sh = SH_29;
         end
         ST_CONV_LON: begin
            mul_a = 35'(lon_ff); mul_b = DEG2RAD_K; mul_sh = SH_29;
         end
         ST_SC_FIN:   mem_we = (phase_ff == PH_LOAD);
         ST_RD_ISSUE: rd_en = 1'b1;
         ST_P_RSWS: begin
            mul_a = 35'(rs_ff); mul_b = $signed(rd_ff.sin);
         end
         ST_P_RCWC: begin
            mul_a = 35'(rc_ff); mul_b = $signed(rd_ff.cos);
         end
         ST_P_DC: begin
            mul_a = $signed(rnd_full[34:0]); mul_b = dc_ff;
         end
         ST_P_SQ: begin
            mul_a = 35'(cang_ff); mul_b = cang_ff;
         end
         ST_VC_FIN: begin
            mul_a  = z_fin;
            mul_b  = (phase_ff == PH_BEAR) ? RAD2DEG_K : KM_K;
            mul_sh = (phase_ff == PH_BEAR) ? SH_38 : SH_30;
         end
         ST_B_T1: begin
            mul_a = 35'(ds_ff); mul_b = $signed(rd_ff.cos);
         end
         ST_B_A: begin
            mul_a = 35'(rc_ff); mul_b = $signed(rd_ff.sin);
         end
         ST_B_B: begin
            mul_a = 35'(rs_ff); mul_b = $signed(rd_ff.cos);
         end
         ST_B_C: begin
            mul_a = $signed(rnd_full[34:0]); mul_b = dc_ff;
         end
         default: begin
            mul_a = 35'sd0;
         end
      endcase
   end

   // ---------------- waypoint store
   assign wr_addr = AW'(eidx_ff);
   assign rd_addr = (phase_ff == PH_BEAR) ? bi_ff[AW-1:0] : idx_ff[AW-1:0];
   assign wr_data = '{lon: lon_r_ff, sin: sc_sin, cos: sc_cos};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         wp_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= wp_mem[rd_addr];
      end
   end

   // ---------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_RESULT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      sh_ff   <= mul_sh;
      case (state_ff)
         ST_IDLE: begin
            func_ff <= req_func[0];
            eidx_ff <= req_entry_index;
            lat_ff  <= (req_lat_deg > LAT_LIMIT) ? LAT_LIMIT :
                       (req_lat_deg < -LAT_LIMIT) ? -LAT_LIMIT : req_lat_deg;
            lon_ff  <= (req_lon_deg > LON_LIMIT) ? LON_LIMIT :
                       (req_lon_deg < -LON_LIMIT) ? -LON_LIMIT : req_lon_deg;
         end
         ST_CONV_LON: lat_r_ff <= rnd_full[31:0];
         ST_CONV_END: begin
            lon_r_ff <= rnd_full[31:0];
            cz_ff    <= {lat_r_ff[31], lat_r_ff[31], lat_r_ff, 1'b0};
            phase_ff <= func_ff ? PH_REF : PH_LOAD;
            empty_ff <= 1'b0;
            if (func_ff && n_w == '0) begin
               empty_ff <= 1'b1;
               bi_ff    <= '0;
               best_ff  <= 23'd0;
               bear_ff  <= 25'd0;
            end
         end
         ST_SC_WRAP: begin
            if (cz_ff > PI_Q30)       cz_ff <= cz_ff - TWO_PI_Q30;
            else if (cz_ff < -PI_Q30) cz_ff <= cz_ff + TWO_PI_Q30;
         end
         ST_SC_FOLD: begin
            cx_ff   <= CORDIC_SCALE;
            cy_ff   <= 36'sd0;
            step_ff <= 5'd0;
            neg_ff  <= 1'b0;
            if (cz_ff > HALF_PI_Q30) begin
               cz_ff  <= cz_ff - PI_Q30;
               neg_ff <= 1'b1;
            end else if (cz_ff < -HALF_PI_Q30) begin
               cz_ff  <= cz_ff + PI_Q30;
               neg_ff <= 1'b1;
            end
         end
         ST_SC_RUN, ST_VC_RUN: begin
            cx_ff   <= cx_nx;
            cy_ff   <= cy_nx;
            cz_ff   <= cz_nx;
            step_ff <= step_ff + 5'd1;
         end
         ST_SC_FIN: begin
            if (phase_ff == PH_REF) begin
               rs_ff    <= sc_sin;
               rc_ff    <= sc_cos;
               idx_ff   <= '0;
               phase_ff <= PH_SCAN;
            end else begin
               ds_ff <= sc_sin;
               dc_ff <= sc_cos;
            end
         end
         ST_RD_WAIT: cz_ff <= {dl_diff[32], dl_diff, 1'b0};
         ST_P_RCWC:  t1_ff <= $signed(rnd_full[32:0]);
         ST_P_SUM: begin
            cang_ff <= (cang_sum > ONE_Q30_S) ? 32'sd1073741824 :
                       (cang_sum < -ONE_Q30_S) ? -32'sd1073741824 : cang_sum[31:0];
         end
         ST_P_SQ2: begin
            // 2^60 - cang^2, root by bit pairs from the top
            sqv_ff <= 62'h1000_0000_0000_0000 - {1'b0, prod_ff[60:0]};
            sqr_ff <= 62'd0;
            sqk_ff <= 5'd30;
         end
         ST_SQRT: begin
            if (sqv_ff >= sq_trial) begin
               sqv_ff <= sqv_ff - sq_trial;
               sqr_ff <= (sqr_ff >> 1) + sq_bit;
            end else begin
               sqr_ff <= sqr_ff >> 1;
            end
            sqk_ff <= sqk_ff - 5'd1;
         end
         ST_VC_LOAD: begin
            step_ff  <= 5'd0;
            vzero_ff <= (vx_src == 36'sd0) && (vy_src == 36'sd0);
            if (vx_src < 36'sd0) begin
               cz_ff <= (vy_src >= 36'sd0) ? PI_Q30 : -PI_Q30;
               cx_ff <= -vx_src;
               cy_ff <= -vy_src;
            end else begin
               cz_ff <= 35'sd0;
               cx_ff <= vx_src;
               cy_ff <= vy_src;
            end
         end
         ST_D_CMP: begin
            if (idx_ff == '0 || d_val < best_ff) begin
               best_ff <= d_val;
               bi_ff   <= idx_ff;
            end
            idx_ff   <= idx_nx;
            phase_ff <= (idx_nx == n_w) ? PH_BEAR : PH_SCAN;
         end
         ST_B_A: t1_ff <= $signed(rnd_full[32:0]);
         ST_B_B: t2_ff <= $signed(rnd_full[33:0]);
         ST_B_D: t2_ff <= t2_ff - $signed(rnd_full[33:0]);
         ST_B_WRAP: begin
            bear_ff <= (b_w2 < 28'sd0) ? 25'd0 :
                       (b_w2 >= FULL_TURN) ? 25'(FULL_TURN - 28'sd1) : b_w2[24:0];
         end
         ST_RESULT: begin
            if (rsp_free) begin
               rsp_idx_ff   <= bi_ff[7:0];
               rsp_dist_ff  <= best_ff;
               rsp_bear_ff  <= bear_ff;
               rsp_empty_ff <= empty_ff;
            end
         end
         default: begin
            step_ff <= step_ff;
         end
      endcase
   end

endmodule
`default_nettype wire
